FILE: hw/rtl/sawm_pkg.sv
// Package for the sliding anagram window matcher.
// Holds defaults, field widths, request op codes and the cell control structs.
// No dependencies.
`default_nettype none

package sawm_pkg;

  localparam int unsigned MaxPatternDef = 256;
  localparam int unsigned AlphabetDef   = 26;
  localparam int unsigned MaxTextDef    = 65536;

  localparam int unsigned OpW     = 2;
  localparam int unsigned LetterW = 5;
  localparam int unsigned IndexW  = 16;

  localparam logic [OpW-1:0] OP_CLEAR   = 2'd0;
  localparam logic [OpW-1:0] OP_PATTERN = 2'd1;
  localparam logic [OpW-1:0] OP_TEXT    = 2'd2;

  // Control for one letter bin of the two histograms.
  typedef struct packed {
    logic clear;
    logic pat_inc;
    logic win_inc;
    logic win_dec;
  } bin_ctrl_t;

  // Control shared by all cells of the window delay line.
  typedef struct packed {
    logic clear;
    logic pat_shift;
    logic text_shift;
  } ring_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sawm_ring_cell.sv
// One cell of the window delay line: a letter slot plus the entry marker.
// Depends on sawm_pkg.
`default_nettype none

module sawm_ring_cell (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  sawm_pkg::ring_ctrl_t             ctrl_i,
  input  wire                              mark_i,
  input  wire [sawm_pkg::LetterW-1:0]      letter_new_i,
  input  wire [sawm_pkg::LetterW-1:0]      letter_prev_i,
  output logic                             mark_o,
  output logic [sawm_pkg::LetterW-1:0]     letter_o
);
  import sawm_pkg::*;

  logic               mark_q, mark_d;
  logic [LetterW-1:0] letter_q, letter_d;

  // The entry marker walks toward the head by one cell per pattern letter.
  always_comb begin
    mark_d = mark_q;
    if (ctrl_i.clear) begin
      mark_d = 1'b0;
    end else if (ctrl_i.pat_shift) begin
      mark_d = mark_i;
    end
  end

  always_comb begin
    letter_d = letter_q;
    if (ctrl_i.text_shift) begin
      letter_d = mark_q ? letter_new_i : letter_prev_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q <= 1'b0;
    end else begin
      mark_q <= mark_d;
    end
  end

  always_ff @(posedge clk_i) begin
    letter_q <= letter_d;
  end

  assign mark_o   = mark_q;
  assign letter_o = letter_q;

endmodule

`default_nettype wire

FILE: hw/rtl/sawm_bin.sv
// One letter bin: pattern count, window count and the equality chain link.
// Depends on sawm_pkg.
`default_nettype none

module sawm_bin #(
  parameter int unsigned CntW = 9
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  sawm_pkg::bin_ctrl_t    ctrl_i,
  input  wire                    eq_i,
  output logic                   eq_o
);
  import sawm_pkg::*;

  logic [CntW-1:0] pat_q, pat_d;
  logic [CntW-1:0] win_q, win_d;
  logic            dec_ok;

  assign dec_ok = ctrl_i.win_dec && (win_q != '0);

  always_comb begin
    pat_d = pat_q;
    win_d = win_q;
    if (ctrl_i.clear) begin
      pat_d = '0;
      win_d = '0;
    end else begin
      if (ctrl_i.pat_inc) begin
        pat_d = pat_q + CntW'(1);
      end
      if (ctrl_i.win_inc && !dec_ok) begin
        win_d = win_q + CntW'(1);
      end else if (!ctrl_i.win_inc && dec_ok) begin
        win_d = win_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q <= '0;
      win_q <= '0;
    end else begin
      pat_q <= pat_d;
      win_q <= win_d;
    end
  end

  // Compare on the updated counts so a match shows for this request.
  assign eq_o = eq_i && (pat_d == win_d);

endmodule

`default_nettype wire

FILE: hw/rtl/sliding_anagram_window_match.sv
// Sliding anagram window matcher, top level.
// Depends on sawm_pkg, sawm_ring_cell and sawm_bin.
//
// Input channel (in_valid_i / in_stall_o, op_i, letter_i): a request clears
// all counts, loads one pattern letter, or streams one text letter. Output
// channel (out_valid_o / out_stall_i, start_index_o): the start position of
// each text window that is a permutation of the pattern.
// One request is taken every cycle while in_stall_o is low. The window is a
// row of MAX_PATTERN cells that shifts once per text letter; letters enter
// at the cell picked by the pattern length and leave at the far end, so the
// dropped letter is always at a fixed place. Each of the ALPHABET bins
// updates and compares its two counts in the same cycle. A match is stored
// in the output register, or in the skid entry if that register is full and
// not popped. The output register is backed by a one-entry skid buffer:
// requests keep flowing while one result waits, and in_stall_o rises only
// once the skid entry is occupied. Reset clears histograms, pattern length,
// text position, entry markers and output buffers, but not the letter slots.
`default_nettype none

module sliding_anagram_window_match #(
  parameter int unsigned MAX_PATTERN = sawm_pkg::MaxPatternDef,
  parameter int unsigned ALPHABET    = sawm_pkg::AlphabetDef,
  parameter int unsigned MAX_TEXT    = sawm_pkg::MaxTextDef
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire [sawm_pkg::OpW-1:0]          op_i,
  input  wire [sawm_pkg::LetterW-1:0]      letter_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic [sawm_pkg::IndexW-1:0]      start_index_o
);
  import sawm_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned PosW = $clog2(MAX_TEXT + 1);
  localparam int unsigned MaxW = (PosW > CntW) ? PosW : CntW;
  localparam int unsigned DW   = (MaxW > IndexW) ? MaxW : IndexW;

  logic            accept;
  logic            letter_ok;
  logic            clear;
  logic            pat_ok;
  logic            text_ok;
  logic            text_live;
  logic            full_now;
  logic            full_next;
  logic            match;
  logic [DW-1:0]   start_full;

  logic [CntW-1:0] len_q, len_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] pos_inc;

  ring_ctrl_t      ring_ctrl;
  logic [MAX_PATTERN-1:0] ring_mark;
  logic [LetterW-1:0]     ring_letter [MAX_PATTERN];
  logic [LetterW-1:0]     old_letter;

  bin_ctrl_t       bin_ctrl [ALPHABET];
  logic [ALPHABET:0] eq_chain;

  logic               out_valid_q, out_valid_d;
  logic [IndexW-1:0]  out_data_q, out_data_d;
  logic               skid_valid_q, skid_valid_d;
  logic [IndexW-1:0]  skid_data_q, skid_data_d;
  logic               pop;

  // ---------------------------------------------------------------- decode
  assign accept    = in_valid_i && !in_stall_o;
  assign letter_ok = 32'(letter_i) < 32'(ALPHABET);
  assign clear     = accept && (op_i == OP_CLEAR);
  assign pat_ok    = accept && (op_i == OP_PATTERN) && letter_ok &&
                     (pos_q == '0) && (len_q < CntW'(MAX_PATTERN));
  assign text_ok   = accept && (op_i == OP_TEXT) && letter_ok &&
                     (pos_q < PosW'(MAX_TEXT));
  assign text_live = text_ok && (len_q != '0);

  assign pos_inc   = pos_q + PosW'(1);
  assign full_now  = DW'(pos_q) >= DW'(len_q);
  assign full_next = DW'(pos_inc) >= DW'(len_q);

  always_comb begin
    len_d = len_q;
    pos_d = pos_q;
    if (clear) begin
      len_d = '0;
      pos_d = '0;
    end else begin
      if (pat_ok) begin
        len_d = len_q + CntW'(1);
      end
      if (text_ok) begin
        pos_d = pos_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      pos_q <= '0;
    end else begin
      len_q <= len_d;
      pos_q <= pos_d;
    end
  end

  // ---------------------------------------------------------- window cells
  assign ring_ctrl.clear      = clear;
  assign ring_ctrl.pat_shift  = pat_ok;
  assign ring_ctrl.text_shift = text_live;
  assign old_letter           = ring_letter[MAX_PATTERN-1];

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_ring
    logic               up_mark;
    logic [LetterW-1:0] prev_letter;

    if (i == MAX_PATTERN - 1) begin : g_tail
      assign up_mark = (len_q == '0);
    end else begin : g_body
      assign up_mark = ring_mark[i+1];
    end

    if (i == 0) begin : g_head
      assign prev_letter = letter_i;
    end else begin : g_link
      assign prev_letter = ring_letter[i-1];
    end

    sawm_ring_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ring_ctrl),
      .mark_i        (up_mark),
      .letter_new_i  (letter_i),
      .letter_prev_i (prev_letter),
      .mark_o        (ring_mark[i]),
      .letter_o      (ring_letter[i])
    );
  end

  // ------------------------------------------------------------ histograms
  assign eq_chain[0] = 1'b1;

  for (genvar b = 0; b < ALPHABET; b++) begin : g_bin
    assign bin_ctrl[b].clear   = clear;
    assign bin_ctrl[b].pat_inc = pat_ok && (32'(letter_i) == b);
    assign bin_ctrl[b].win_inc = text_live && (32'(letter_i) == b);
    assign bin_ctrl[b].win_dec = text_live && full_now && (32'(old_letter) == b);

    sawm_bin #(
      .CntW (CntW)
    ) u_bin (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (bin_ctrl[b]),
      .eq_i   (eq_chain[b]),
      .eq_o   (eq_chain[b+1])
    );
  end

  assign match      = text_live && full_next && eq_chain[ALPHABET];
  assign start_full = DW'(pos_inc) - DW'(len_q);

  // --------------------------------------------------- output and skid
  assign pop        = out_valid_q && !out_stall_i;
  assign in_stall_o = skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (match) begin
      if (!out_valid_q || pop) begin
        out_valid_d = 1'b1;
        out_data_d  = start_full[IndexW-1:0];
      end else begin
        skid_valid_d = 1'b1;
        skid_data_d  = start_full[IndexW-1:0];
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_valid_o   = out_valid_q;
  assign start_index_o = out_data_q;

endmodule

`default_nettype wire

FILE: bench/sawm_checker.sv
// Checker for the sliding anagram window matcher: watches both channels,
// keeps its own histograms, window ring and positions, and compares results.
// Depends on sawm_pkg.
`default_nettype none

module sawm_checker
  import sawm_pkg::*;
(
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  input  wire                in_stall_i,
  input  wire [OpW-1:0]      op_i,
  input  wire [LetterW-1:0]  letter_i,
  input  wire                out_valid_i,
  input  wire                out_stall_i,
  input  wire [IndexW-1:0]   start_index_i,
  output int                 mismatch_cnt_o,
  output int                 owed_o
);

  localparam int unsigned Alpha   = AlphabetDef;
  localparam int unsigned MaxPat  = MaxPatternDef;
  localparam int unsigned MaxText = MaxTextDef;

  logic [8:0]         pat_hist [Alpha];
  logic [8:0]         win_hist [Alpha];
  logic [LetterW-1:0] ring [MaxPat];
  logic [8:0]         pat_len;
  logic [16:0]        text_pos;
  logic [IndexW-1:0]  match_starts_q [$];
  logic [IndexW-1:0]  want_idx;
  int                 mismatches = 0;

  assign mismatch_cnt_o = mismatches;

  task automatic clear_matcher();
    for (int i = 0; i < Alpha; i++) begin
      pat_hist[i] = '0;
      win_hist[i] = '0;
    end
    pat_len  = '0;
    text_pos = '0;
  endtask

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
  endfunction

  // One accepted request; queues the window start when the histograms agree.
  task automatic step_matcher(logic [OpW-1:0] op, logic [LetterW-1:0] letter);
    logic [16:0]        slot;
    logic [LetterW-1:0] gone;
    bit                 same;
    case (op)
      OP_CLEAR: begin
        clear_matcher();
      end
      OP_PATTERN: begin
        if (letter < Alpha && text_pos == 0 && pat_len < MaxPat) begin
          pat_hist[letter]++;
          pat_len++;
        end
      end
      OP_TEXT: begin
        if (letter < Alpha && text_pos < MaxText) begin
          if (pat_len == 0) begin
            text_pos++;
          end else begin
            slot = text_pos % pat_len;
            // full window: the letter in this slot drops out
            if (text_pos >= pat_len) begin
              gone = ring[slot];
              if (win_hist[gone] != 0) win_hist[gone]--;
            end
            ring[slot] = letter;
            win_hist[letter]++;
            text_pos++;
            if (text_pos >= pat_len) begin
              same = 1'b1;
              for (int i = 0; i < Alpha; i++) begin
                if (pat_hist[i] != win_hist[i]) same = 1'b0;
              end
              if (same) match_starts_q = {match_starts_q, IndexW'(text_pos - pat_len)};
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      clear_matcher();
      match_starts_q.delete();
    end else begin
      // result first: it belongs to a request taken at an earlier edge
      if (out_valid_i && !out_stall_i) begin
        if (match_starts_q.size() == 0) begin
          note_mismatch($sformatf("unexpected start_index %0d", start_index_i));
        end else begin
          want_idx = match_starts_q.pop_front();
          if (want_idx !== start_index_i) begin
            note_mismatch($sformatf("start_index expected %0d, got %0d",
                                    want_idx, start_index_i));
          end
        end
      end
      if (in_valid_i && !in_stall_i) step_matcher(op_i, letter_i);
    end
    owed_o = match_starts_q.size();
  end

endmodule

`default_nettype wire

FILE: bench/sliding_anagram_window_match_tb.sv
// Testbench top for the sliding anagram window matcher: clock, reset, request
// stimulus, output stall control, watchdog and verdict.
// Depends on sawm_pkg, sliding_anagram_window_match and sawm_checker.
`default_nettype none

module sliding_anagram_window_match_tb;
  import sawm_pkg::*;

  localparam int unsigned ItemsTarget = 1750;
  localparam int unsigned CalmTail    = 250;
  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned HoldCycles  = 300;
  localparam logic [OpW-1:0] OpUnused = 2'd3;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic [OpW-1:0]     op        = OP_CLEAR;
  logic [LetterW-1:0] letter    = '0;
  logic               out_stall = 1'b0;
  wire                in_stall;
  wire                out_valid;
  wire [IndexW-1:0]   start_index;
  int                 mismatches;
  int                 owed;

  bit                 tx_idle_on  = 1'b0;
  bit                 rx_idle_on  = 1'b0;
  int                 holds_asked = 0;
  int                 holds_done  = 0;
  int                 sent        = 0;
  int                 quiet       = 0;
  logic [LetterW-1:0] pat_q [$];
  logic [LetterW-1:0] perm_q [$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sliding_anagram_window_match u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .op_i         (op),
    .letter_i     (letter),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .start_index_o(start_index)
  );

  sawm_checker u_chk (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .op_i          (op),
    .letter_i      (letter),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .start_index_i (start_index),
    .mismatch_cnt_o(mismatches),
    .owed_o        (owed)
  );

  // Valid stays high from one request to the next unless a gap is inserted.
  task automatic send(logic [OpW-1:0] o, logic [LetterW-1:0] l);
    int gap;
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= o;
    letter   <= l;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 3))
      0: send(OpUnused, LetterW'($urandom_range(0, 31)));
      1: send(OP_PATTERN, LetterW'($urandom_range(0, 31)));
      2: send(OP_TEXT, LetterW'($urandom_range(26, 31)));
      default: send(OpW'($urandom_range(0, 3)), LetterW'($urandom_range(0, 31)));
    endcase
  endtask

  task automatic shuffle_pattern();
    int                 i;
    int                 j;
    logic [LetterW-1:0] t;
    perm_q = pat_q;
    for (i = perm_q.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = perm_q[i];
      perm_q[i] = perm_q[j];
      perm_q[j] = t;
    end
  endtask

  task automatic send_perm();
    shuffle_pattern();
    foreach (perm_q[k]) send(OP_TEXT, perm_q[k]);
  endtask

  // Clear, load a pattern from a narrow letter range, then stream text that
  // is mostly permutations of it so windows match often.
  task automatic run_search(int plen, int ntext, int span);
    int                 base;
    int                 k;
    logic [LetterW-1:0] l;
    base = $urandom_range(0, 25 - span);
    if ($urandom_range(0, 9) != 0) send(OP_CLEAR, LetterW'($urandom_range(0, 31)));
    pat_q.delete();
    for (k = 0; k < plen; k++) begin
      l = LetterW'(base + $urandom_range(0, span));
      pat_q = {pat_q, l};
      send(OP_PATTERN, l);
      if ($urandom_range(0, 15) == 0) send_noise();
    end
    k = 0;
    while (k < ntext) begin
      if (plen > 0 && $urandom_range(0, 1) == 0) begin
        send_perm();
        k += plen;
      end else begin
        send(OP_TEXT, LetterW'(base + $urandom_range(0, span)));
        k++;
      end
      if ($urandom_range(0, 19) == 0) send_noise();
    end
  endtask

  // Output side: random stall bursts, plus a long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QuietLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int                 plen;
    int                 r;
    logic [LetterW-1:0] l;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty pattern, out-of-range letters, unused op, pattern after text
    send(OP_TEXT, 5'd1);
    send(OP_CLEAR, 5'd31);
    send(OP_PATTERN, 5'd25);
    send(OP_PATTERN, 5'd0);
    send(OP_PATTERN, 5'd26);
    send(OP_PATTERN, 5'd31);
    send(OpUnused, 5'd31);
    send(OpUnused, 5'd0);
    send(OP_TEXT, 5'd31);
    send(OP_TEXT, 5'd0);
    send(OP_TEXT, 5'd25);
    send(OP_TEXT, 5'd0);
    send(OP_TEXT, 5'd30);
    send(OP_TEXT, 5'd1);
    send(OP_PATTERN, 5'd2);
    send(OP_TEXT, 5'd0);
    send(OP_TEXT, 5'd25);
    send(OP_CLEAR, 5'd0);
    send(OP_PATTERN, 5'd16);
    send(OP_TEXT, 5'd16);
    send(OP_TEXT, 5'd16);
    send(OP_TEXT, 5'd23);
    send(OP_TEXT, 5'd16);

    // every text letter matches while the output is held off
    send(OP_CLEAR, 5'd0);
    send(OP_PATTERN, 5'd0);
    holds_asked++;
    repeat (40) send(OP_TEXT, 5'd0);

    // pattern beyond capacity, then windows as long as the ring
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send(OP_CLEAR, 5'd0);
    pat_q.delete();
    repeat (MaxPatternDef + 4) begin
      l = LetterW'($urandom_range(0, 1));
      if (pat_q.size() < MaxPatternDef) pat_q = {pat_q, l};
      send(OP_PATTERN, l);
    end
    send_perm();
    send_perm();
    repeat (10) send(OP_TEXT, LetterW'($urandom_range(0, 1)));

    while (sent < ItemsTarget) begin
      tx_idle_on = (sent < ItemsTarget - CalmTail) && ($urandom_range(0, 3) != 0);
      rx_idle_on = (sent < ItemsTarget - CalmTail) && ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 19);
      if (r == 0) plen = 0;
      else if (r < 3) plen = $urandom_range(7, 40);
      else plen = $urandom_range(1, 6);
      run_search(plen, $urandom_range(plen + 2, 3 * plen + 20),
                 (plen > 6) ? $urandom_range(0, 25) : $urandom_range(0, 5));
    end
    in_valid <= 1'b0;

    while (owed != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && owed == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
hw/rtl/sawm_pkg.sv
hw/rtl/sawm_ring_cell.sv
hw/rtl/sawm_bin.sv
hw/rtl/sliding_anagram_window_match.sv
bench/sawm_checker.sv
bench/sliding_anagram_window_match_tb.sv
